FILE: hdl/mks_pkg.sv
// Package for the matrix keypad scanner: sizes, phase codes, register
// indexes and the structs shared by the scanner modules. No dependencies.
`default_nettype none

package mks_pkg;

  localparam int unsigned NumColumns   = 3;
  localparam int unsigned NumRows      = 4;
  localparam int unsigned SweepPauseMs = 5;

  localparam int unsigned ColW  = (NumColumns > 1) ? $clog2(NumColumns) : 1;
  localparam int unsigned RowW  = (NumRows > 1) ? $clog2(NumRows) : 1;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ColW-1:0] LastCol = ColW'(NumColumns - 1);
  localparam logic [RowW-1:0] LastRow = RowW'(NumRows - 1);
  localparam logic [7:0]      PauseMs = 8'(SweepPauseMs);

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE    = 2'd0,
    REG_TIMEOUT     = 2'd1,
    REG_PRESS_LEVEL = 2'd2
  } reg_idx_e;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_CHECK    = 5'b00010,
    PH_DEBOUNCE = 5'b00100,
    PH_RELEASE  = 5'b01000,
    PH_PAUSE    = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0]  debounce_ms;
    logic [15:0] timeout_ms;
    logic        press_level;
  } cfg_t;

  typedef struct packed {
    logic       start_req;
    logic       ms_tick;
    logic [3:0] row_levels;
  } item_t;

  typedef struct packed {
    logic [2:0] column_drive;
    logic       busy_res;
    logic       key_valid;
    logic [3:0] key_code;
    logic       timed_out;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/mks_if.sv
// Handshake interfaces for the keypad scanner: input items, result items
// and configuration writes. Depends on mks_pkg.
`default_nettype none

interface mks_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic       ms_tick;
  logic [3:0] row_levels;
  modport source (output valid, output start_req, output ms_tick, output row_levels,
                  input ready);
  modport sink (input valid, input start_req, input ms_tick, input row_levels,
                output ready);
endinterface

interface mks_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] column_drive;
  logic       busy_res;
  logic       key_valid;
  logic [3:0] key_code;
  logic       timed_out;
  modport source (output valid, output column_drive, output busy_res, output key_valid,
                  output key_code, output timed_out, input ready);
  modport sink (input valid, input column_drive, input busy_res, input key_valid,
                input key_code, input timed_out, output ready);
endinterface

interface mks_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mks_pkg::CfgIdxW-1:0]  index;
  logic [mks_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/mks_cfg_regs.sv
// Configuration register file of the keypad scanner.
// Depends on mks_pkg.
`default_nettype none

module mks_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         wr_en_i,
  input  wire logic [mks_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  wire logic [mks_pkg::CfgDataW-1:0] wr_data_i,
  output mks_pkg::cfg_t                     cfg_o
);
  import mks_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (reg_idx_e'(wr_idx_i))
        REG_DEBOUNCE:    cfg_d.debounce_ms = wr_data_i[7:0];
        REG_TIMEOUT:     cfg_d.timeout_ms  = wr_data_i[15:0];
        REG_PRESS_LEVEL: cfg_d.press_level = wr_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= 8'd20;
      cfg_q.timeout_ms  <= 16'd0;
      cfg_q.press_level <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/mks_fsm.sv
// Scan state machine of the keypad scanner: takes one item per accepted
// handshake and forms its result. Depends on mks_pkg.
`default_nettype none

module mks_fsm (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   accept_i,
  input  wire mks_pkg::item_t item_i,
  input  wire mks_pkg::cfg_t  cfg_i,
  output mks_pkg::res_t  res_o
);
  import mks_pkg::*;

  phase_e          phase_q, phase_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [7:0]      wait_q, wait_d;
  logic [15:0]     elapsed_q, elapsed_d;

  logic       pressed;
  logic [7:0] wait_inc;
  logic [15:0] elapsed_inc;
  logic [7:0] key_sum;

  assign pressed  = (item_i.row_levels[row_q] == cfg_i.press_level);
  assign wait_inc = wait_q + 8'd1;
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign key_sum  = 8'(NumColumns) * 8'(row_q) + 8'(col_q) + 8'd1;

  always_comb begin
    phase_d   = phase_q;
    col_d     = col_q;
    row_d     = row_q;
    wait_d    = wait_q;
    elapsed_d = elapsed_q;
    res_o     = '0;

    unique case (phase_q)
      PH_CHECK, PH_DEBOUNCE: begin
        if (phase_q == PH_CHECK && pressed) begin
          wait_d  = 8'd0;
          phase_d = PH_DEBOUNCE;
        end else if (phase_q == PH_DEBOUNCE && wait_q < cfg_i.debounce_ms) begin
          if (item_i.ms_tick) wait_d = wait_inc;
        end else if (phase_q == PH_DEBOUNCE && pressed) begin
          phase_d = PH_RELEASE;
        end else if (row_q != LastRow) begin
          row_d   = row_q + RowW'(1);
          phase_d = PH_CHECK;
        end else if (col_q != LastCol) begin
          row_d   = '0;
          col_d   = col_q + ColW'(1);
          phase_d = PH_CHECK;
        end else begin
          row_d   = '0;
          col_d   = '0;
          wait_d  = 8'd0;
          phase_d = PH_PAUSE;
        end
      end
      PH_RELEASE: begin
        if (!pressed) begin
          res_o.key_valid = 1'b1;
          res_o.key_code  = key_sum[3:0];
          phase_d         = PH_IDLE;
        end
      end
      PH_PAUSE: begin
        if (item_i.ms_tick) begin
          wait_d    = wait_inc;
          elapsed_d = elapsed_inc;
          if (wait_inc >= PauseMs) begin
            wait_d = 8'd0;
            if (cfg_i.timeout_ms != 16'd0 && elapsed_inc >= cfg_i.timeout_ms) begin
              res_o.timed_out = 1'b1;
              phase_d         = PH_IDLE;
            end else begin
              col_d   = '0;
              row_d   = '0;
              phase_d = PH_CHECK;
            end
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (item_i.start_req) begin
          col_d     = '0;
          row_d     = '0;
          wait_d    = 8'd0;
          elapsed_d = 16'd0;
          phase_d   = PH_CHECK;
        end
      end
    endcase

    res_o.busy_res = (phase_d != PH_IDLE);
    if (phase_d != PH_IDLE && phase_d != PH_PAUSE && 32'(col_d) < 32'd3) begin
      res_o.column_drive = 3'(3'd1 << col_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      wait_q    <= 8'd0;
      elapsed_q <= 16'd0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      col_q     <= col_d;
      row_q     <= row_d;
      wait_q    <= wait_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mks_out_reg.sv
// Result register of the keypad scanner; holds one finished item while the
// sink stalls and lets the next item in as it is taken. Depends on mks_pkg.
`default_nettype none

module mks_out_reg (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire mks_pkg::res_t res_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output mks_pkg::res_t res_o
);
  import mks_pkg::*;

  logic valid_q;
  res_t res_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/matrix_keypad_scanner_unit.sv
// Top level of the 3x4 matrix keypad scanner: configuration registers,
// scan state machine and result register. Depends on mks_pkg and mks_if.
// The result of an item is registered and shown in the cycle after it is accepted.
// Throughput: one item per cycle unless the result register is full and the sink stalls;
// the result register alone sets the pace. Reset: asynchronous, active low; idle phase,
// counters zero, registers at their defaults (debounce 20, timeout 0, press level 0), no result held.
`default_nettype none

module matrix_keypad_scanner_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mks_in_if.sink    in_s,
  mks_out_if.source out_m,
  mks_cfg_if.sink   cfg_s
);
  import mks_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res_d, res_q;
  logic  in_ready;
  logic  out_valid;

  assign cfg_s.ready = 1'b1;
  assign in_s.ready  = in_ready;

  assign item.start_req  = in_s.start_req;
  assign item.ms_tick    = in_s.ms_tick;
  assign item.row_levels = in_s.row_levels;

  mks_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_s.valid),
    .wr_idx_i  (cfg_s.index),
    .wr_data_i (cfg_s.data),
    .cfg_o     (cfg)
  );

  mks_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_s.valid && in_ready),
    .item_i   (item),
    .cfg_i    (cfg),
    .res_o    (res_d)
  );

  mks_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .in_ready_o  (in_ready),
    .res_i       (res_d),
    .out_valid_o (out_valid),
    .out_ready_i (out_m.ready),
    .res_o       (res_q)
  );

  assign out_m.valid        = out_valid;
  assign out_m.column_drive = res_q.column_drive;
  assign out_m.busy_res     = res_q.busy_res;
  assign out_m.key_valid    = res_q.key_valid;
  assign out_m.key_code     = res_q.key_code;
  assign out_m.timed_out    = res_q.timed_out;

endmodule

`default_nettype wire

FILE: hdl/mks_checker.sv
// Port-level checks for the keypad scanner, bound to the top level.
// Depends on matrix_keypad_scanner_unit.
`default_nettype none

module mks_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] column_drive_i,
  input wire logic       busy_res_i,
  input wire logic       key_valid_i,
  input wire logic [3:0] key_code_i,
  input wire logic       timed_out_i
);

  // A reported key or a timeout always ends the read.
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (key_valid_i || timed_out_i) |-> !busy_res_i && column_drive_i == 3'd0)
    else $error("key or timeout reported while busy");

  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && key_valid_i |-> key_code_i != 4'd0 && key_code_i <= 4'd12 && !timed_out_i)
    else $error("bad key report");

  a_no_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !key_valid_i |-> key_code_i == 4'd0)
    else $error("key code without key report");

  a_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0(column_drive_i) && (busy_res_i || column_drive_i == 3'd0))
    else $error("bad column drive");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(key_code_i) && $stable(busy_res_i))
    else $error("stalled item changed");

endmodule

bind matrix_keypad_scanner_unit mks_checker u_mks_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_m.valid),
  .out_ready_i    (out_m.ready),
  .column_drive_i (out_m.column_drive),
  .busy_res_i     (out_m.busy_res),
  .key_valid_i    (out_m.key_valid),
  .key_code_i     (out_m.key_code),
  .timed_out_i    (out_m.timed_out)
);

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for matrix_keypad_scanner_unit: a scoreboard predicts every result
// item, with a simulated key matrix that answers the driven column. Depends on mks_pkg, mks_if.
`timescale 1ns / 100ps

module testbench;
  import mks_pkg::*;

  localparam int unsigned RandomItems = 1450;
  localparam int unsigned CycleLimit  = 600_000;

  typedef struct {
    logic       start;
    logic       tick;
    logic       use_key;
    logic       key_on;
    logic [1:0] key_col;
    logic [3:0] levels;
  } kp_item_t;

  logic clk_i;
  logic rst_ni;

  mks_in_if  in_if ();
  mks_out_if out_if ();
  mks_cfg_if cfg_if ();

  matrix_keypad_scanner_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_s   (in_if),
    .out_m  (out_if),
    .cfg_s  (cfg_if)
  );

  kp_item_t    keypad_items[$];
  res_t        scan_results_due[$];
  int unsigned fault_count;
  int unsigned cycle_count;

  phase_e          scan_phase;
  logic [ColW-1:0] scan_col;
  logic [RowW-1:0] scan_row;
  logic [7:0]      settle_cnt;
  logic [15:0]     pause_ms;
  logic [7:0]      cfg_debounce;
  logic [15:0]     cfg_timeout;
  logic            cfg_press;
  logic [2:0]      shown_drive;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic coin(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic void step_row();
    if (scan_row == LastRow) begin
      scan_row = '0;
      if (scan_col == LastCol) begin
        scan_col = '0;
        settle_cnt = '0;
        scan_phase = PH_PAUSE;
      end else begin
        scan_col = scan_col + 1'b1;
        scan_phase = PH_CHECK;
      end
    end else begin
      scan_row = scan_row + 1'b1;
      scan_phase = PH_CHECK;
    end
  endfunction

  function automatic res_t scan_predict(input logic start, input logic tick,
                                        input logic [3:0] levels);
    res_t r;
    logic pressed;
    r = '0;
    pressed = (levels[scan_row] == cfg_press);
    case (scan_phase)
      PH_CHECK: begin
        if (pressed) begin
          settle_cnt = '0;
          scan_phase = PH_DEBOUNCE;
        end else begin
          step_row();
        end
      end
      PH_DEBOUNCE: begin
        if (settle_cnt >= cfg_debounce) begin
          if (pressed) scan_phase = PH_RELEASE;
          else step_row();
        end else if (tick) begin
          settle_cnt = settle_cnt + 1'b1;
        end
      end
      PH_RELEASE: begin
        if (!pressed) begin
          r.key_valid = 1'b1;
          r.key_code = 4'(NumColumns * scan_row + scan_col + 1);
          scan_phase = PH_IDLE;
        end
      end
      PH_PAUSE: begin
        if (tick) begin
          settle_cnt = settle_cnt + 1'b1;
          if (pause_ms != 16'hFFFF) pause_ms = pause_ms + 1'b1;
          if (settle_cnt >= PauseMs) begin
            settle_cnt = '0;
            if (cfg_timeout != '0 && pause_ms >= cfg_timeout) begin
              r.timed_out = 1'b1;
              scan_phase = PH_IDLE;
            end else begin
              scan_col = '0;
              scan_row = '0;
              scan_phase = PH_CHECK;
            end
          end
        end
      end
      default: begin
        scan_phase = PH_IDLE;
        if (start) begin
          scan_col = '0;
          scan_row = '0;
          settle_cnt = '0;
          pause_ms = '0;
          scan_phase = PH_CHECK;
        end
      end
    endcase
    r.busy_res = (scan_phase != PH_IDLE);
    if (r.busy_res && scan_phase != PH_PAUSE) r.column_drive = 3'(1 << scan_col);
    shown_drive = r.column_drive;
    return r;
  endfunction

  function automatic void push_item(input logic start, input logic tick, input logic use_key,
                                    input logic key_on, input logic [1:0] col,
                                    input logic [3:0] levels);
    kp_item_t it;
    it.start = start;
    it.tick = tick;
    it.use_key = use_key;
    it.key_on = key_on;
    it.key_col = col;
    it.levels = levels;
    keypad_items.push_back(it);
  endfunction

  // One key read: a start, a key held long enough to pass debounce most of the time, then a
  // release. Some reads press nothing, some holds are short, and noise items are mixed in.
  function automatic int unsigned queue_read(input int unsigned deb, input int unsigned tick_pct);
    int unsigned hold;
    int unsigned rel;
    logic [1:0]  col;
    logic [3:0]  mask;
    logic        no_key;
    col = 2'($urandom_range(0, NumColumns - 1));
    mask = coin(20) ? 4'($urandom_range(1, 15)) : 4'(1 << $urandom_range(0, NumRows - 1));
    no_key = coin(20);
    if (no_key) hold = $urandom_range(10, 80);
    else if (coin(20)) hold = $urandom_range(0, 14 + deb);
    else hold = 14 + deb * 130 / tick_pct + $urandom_range(0, 12);
    rel = $urandom_range(1, 6);
    push_item(1'b1, coin(tick_pct), 1'b1, !no_key, col, mask);
    for (int unsigned k = 0; k < hold; k++) begin
      if (coin(10)) push_item(coin(20), coin(50), 1'b0, 1'b0, 2'd0, 4'($urandom_range(0, 15)));
      else push_item(coin(5), coin(tick_pct), 1'b1, !no_key && coin(95), col, mask);
    end
    for (int unsigned k = 0; k < rel; k++) push_item(1'b0, coin(tick_pct), 1'b1, 1'b0, col, mask);
    return 1 + hold + rel;
  endfunction

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_DEBOUNCE:    cfg_debounce = value[7:0];
      REG_TIMEOUT:     cfg_timeout = value;
      REG_PRESS_LEVEL: cfg_press = value[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (keypad_items.size() != 0 || in_if.valid || scan_results_due.size() != 0);
    @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left;
  int unsigned gap_left;
  kp_item_t    drv_item;
  logic [3:0]  drv_levels;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.start_req  <= 1'b0;
      in_if.ms_tick    <= 1'b0;
      in_if.row_levels <= 4'h0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        scan_results_due.push_back(scan_predict(in_if.start_req, in_if.ms_tick,
                                                in_if.row_levels));
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left = coin(25) ? 0 : $urandom_range(1, 8);
          burst_left = coin(10) ? $urandom_range(60, 150) : $urandom_range(1, 24);
        end
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (keypad_items.size() != 0) begin
          drv_item = keypad_items.pop_front();
          drv_levels = drv_item.levels;
          if (drv_item.use_key) begin
            for (int r = 0; r < 4; r++) begin
              drv_levels[r] = (drv_item.key_on && shown_drive[drv_item.key_col] &&
                               drv_item.levels[r]) ? cfg_press : !cfg_press;
            end
          end
          in_if.valid      <= 1'b1;
          in_if.start_req  <= drv_item.start;
          in_if.ms_tick    <= drv_item.tick;
          in_if.row_levels <= drv_levels;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern is redrawn at random; one long hold-off mid-run.
  int unsigned hold_left;
  int unsigned stall_mode;
  int unsigned mode_left;
  int unsigned results_seen;
  logic        long_hold_done;
  res_t        due;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
      stall_mode = 0;
      mode_left = 0;
      results_seen = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (scan_results_due.size() == 0) begin
          $error("result item arrived with none outstanding");
          fault_count++;
        end else begin
          due = scan_results_due.pop_front();
          check_field("column_drive", 4'(due.column_drive), 4'(out_if.column_drive));
          check_field("busy_res", 4'(due.busy_res), 4'(out_if.busy_res));
          check_field("key_valid", 4'(due.key_valid), 4'(out_if.key_valid));
          check_field("key_code", due.key_code, out_if.key_code);
          check_field("timed_out", 4'(due.timed_out), 4'(out_if.timed_out));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 600) begin
        long_hold_done = 1'b1;
        hold_left = 250;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 80);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= !coin(30);
          2: out_if.ready <= coin(25);
          default: out_if.ready <= (mode_left % 3) != 0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned phase_no;
    int unsigned fed;
    int unsigned chunk;
    int unsigned tick_pct;
    int unsigned pick;
    logic [7:0]  deb;
    logic [15:0] tmo;
    logic        press;
    logic        write_all;

    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.start_req = 1'b0;
    in_if.ms_tick = 1'b0;
    in_if.row_levels = 4'h0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_DEBOUNCE;
    cfg_if.data = '0;
    fault_count = 0;
    cycle_count = 0;
    scan_phase = PH_IDLE;
    scan_col = '0;
    scan_row = '0;
    settle_cnt = '0;
    pause_ms = '0;
    cfg_debounce = 8'd20;
    cfg_timeout = '0;
    cfg_press = 1'b0;
    shown_drive = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero debounce read of key 4 with a start while busy, then a read that
    // finds nothing and ends by timeout after the first pause.
    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_TIMEOUT, 16'd1);
    write_reg(REG_PRESS_LEVEL, 16'd1);
    push_item(1'b0, 1'b1, 1'b0, 1'b0, 2'd0, 4'hF);
    push_item(1'b1, 1'b0, 1'b1, 1'b1, 2'd0, 4'b0010);
    push_item(1'b0, 1'b1, 1'b1, 1'b1, 2'd0, 4'b0010);
    push_item(1'b1, 1'b0, 1'b1, 1'b1, 2'd0, 4'b0010);
    push_item(1'b0, 1'b0, 1'b1, 1'b1, 2'd0, 4'b0010);
    push_item(1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 4'b0010);
    push_item(1'b1, 1'b1, 1'b0, 1'b0, 2'd0, 4'h0);
    for (int k = 0; k < 17; k++) push_item(1'b0, 1'b1, 1'b0, 1'b0, 2'd0, 4'h0);

    phase_no = 0;
    fed = 0;
    while (fed < RandomItems) begin
      wait_drained();
      write_all = (phase_no < 3);
      case (phase_no)
        0: begin
          deb = 8'd0;
          tmo = 16'd0;
          press = 1'b0;
        end
        1: begin
          deb = 8'd255;
          tmo = 16'hFFFF;
          press = 1'b1;
        end
        2: begin
          deb = 8'd1;
          tmo = 16'd5;
          press = 1'b0;
        end
        default: begin
          deb = coin(10) ? 8'($urandom_range(7, 40)) : 8'($urandom_range(0, 6));
          pick = $urandom_range(0, 3);
          case (pick)
            0: tmo = 16'd0;
            1: tmo = 16'($urandom_range(1, 30));
            2: tmo = 16'($urandom_range(31, 200));
            default: tmo = 16'hFFFF;
          endcase
          press = coin(50);
        end
      endcase
      if (write_all || coin(70)) write_reg(REG_DEBOUNCE, {8'($urandom), deb});
      if (write_all || coin(70)) write_reg(REG_TIMEOUT, tmo);
      if (write_all || coin(70)) write_reg(REG_PRESS_LEVEL, {15'($urandom), press});
      tick_pct = (phase_no == 1) ? 95 : $urandom_range(30, 100);
      chunk = 0;
      while (chunk < 110) chunk += queue_read(cfg_debounce, tick_pct);
      fed += chunk;
      phase_no++;
    end
    wait_drained();

    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
